### sv/pidsg_pkg.sv
// ----------------------------------------------------------------------------
// pidsg_pkg
// shared types and constants of the sectional-gain pid regulator
// ----------------------------------------------------------------------------
package pidsg_pkg;

  localparam int GAIN_W      = 32;
  localparam int LIMIT_W     = 31;
  localparam int INTEG_W     = 32;
  localparam int TERM_W      = 48;
  localparam int REG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  // largest magnitude of a scaled term
  localparam logic [TERM_W-1:0] TERM_MAX = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN       = 4'd0,
    REG_PROP_GAIN_LARGE = 4'd1,
    REG_SECTION_ENABLE  = 4'd2,
    REG_ERROR_THRESHOLD = 4'd3,
    REG_INTEGRAL_GAIN   = 4'd4,
    REG_DERIV_GAIN      = 4'd5,
    REG_INTEGRAL_LIMIT  = 4'd6,
    REG_OUTPUT_LIMIT    = 4'd7
  } reg_idx_t;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN       = 32'd16384000;
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN_LARGE = 32'd26214400;
  localparam logic               RST_SECTION_ENABLE  = 1'b0;
  localparam logic [GAIN_W-1:0]  RST_ERROR_THRESHOLD = 32'd65536000;
  localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN   = 32'd327680;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN      = 32'd0;
  localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT  = 31'd327680000;
  localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT    = 31'd1048576000;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  prop_gain_large;
    logic               section_enable;
    logic [GAIN_W-1:0]  error_threshold;
    logic [GAIN_W-1:0]  integral_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### sv/pidsg_in_if.sv
// ----------------------------------------------------------------------------
// pidsg_in_if
// sample channel: reference and feedback of one control tick
// ----------------------------------------------------------------------------
interface pidsg_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] reference;
  logic signed [DATA_WIDTH-1:0] feedback;

  modport source (output valid, output reference, output feedback, input ready);
  modport sink   (input valid, input reference, input feedback, output ready);
endinterface

### sv/pidsg_out_if.sv
// ----------------------------------------------------------------------------
// pidsg_out_if
// result channel: clamped drive and saturation flags
// ----------------------------------------------------------------------------
interface pidsg_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         output_saturated;
  logic                         integral_saturated;

  modport source (output valid, output drive, output output_saturated,
                  output integral_saturated, input ready);
  modport sink   (input valid, input drive, input output_saturated,
                  input integral_saturated, output ready);
endinterface

### sv/pidsg_cfg_if.sv
// ----------------------------------------------------------------------------
// pidsg_cfg_if
// register write channel: index and write data
// ----------------------------------------------------------------------------
interface pidsg_cfg_if import pidsg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/pidsg_queue.sv
// ----------------------------------------------------------------------------
// pidsg_queue
// small register queue between front and back
// ----------------------------------------------------------------------------
module pidsg_queue import pidsg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output queue_status_t    status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

### sv/pidsg_front.sv
// ----------------------------------------------------------------------------
// pidsg_front
// forms error, magnitude, gain section and clipped error difference
// ----------------------------------------------------------------------------
module pidsg_front import pidsg_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  pidsg_in_if.sink                        sample,
  input  cfg_t                            cfg,
  input  queue_status_t                   qstat,
  output logic                            push,
  output logic [2*DATA_WIDTH+5:0]         job
);

  localparam int MAG_W  = DATA_WIDTH + 1;
  localparam int DIFF_W = DATA_WIDTH + 2;
  localparam int CMP_W  = (MAG_W > GAIN_W) ? MAG_W : GAIN_W;
  localparam int CLIP_W = (DIFF_W > TERM_W) ? DIFF_W : TERM_W;

  logic [MAG_W-1:0]  err;
  logic [MAG_W-1:0]  previous_error;
  logic              err_neg;
  logic [MAG_W-1:0]  err_mag;
  logic              big_err;
  logic [DIFF_W-1:0] diff;
  logic              diff_neg;
  logic [DIFF_W-1:0] diff_abs;
  logic [DIFF_W-1:0] diff_mag;

  assign sample.ready = !qstat.full;
  assign push         = sample.valid && sample.ready;

  always_comb begin
    err      = {sample.reference[DATA_WIDTH-1], sample.reference}
             - {sample.feedback[DATA_WIDTH-1], sample.feedback};
    err_neg  = err[MAG_W-1];
    err_mag  = err_neg ? (~err + 1'b1) : err;
    big_err  = cfg.section_enable
             && (CMP_W'(err_mag) >= CMP_W'(cfg.error_threshold));
    diff     = {err[MAG_W-1], err} - {previous_error[MAG_W-1], previous_error};
    diff_neg = diff[DIFF_W-1];
    diff_abs = diff_neg ? (~diff + 1'b1) : diff;
    // clip the difference to the term range before scaling
    if (CLIP_W'(diff_abs) > CLIP_W'(TERM_MAX)) begin
      diff_mag = DIFF_W'(TERM_MAX);
    end else begin
      diff_mag = diff_abs;
    end
    job = {err_neg, err_mag, big_err, diff_neg, diff_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
    end else if (push) begin
      previous_error <= err;
    end
  end

endmodule

### sv/pidsg_back.sv
// ----------------------------------------------------------------------------
// pidsg_back
// gain products, integral update with clamp, output sum with clamp
// ----------------------------------------------------------------------------
module pidsg_back import pidsg_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [2*DATA_WIDTH+5:0]       job,
  input  queue_status_t                 qstat,
  output logic                          pop,
  input  cfg_t                          cfg,
  input  logic [LIMIT_W-1:0]            drive_limit,
  pidsg_out_if.source                   result
);

  localparam int MAG_W  = DATA_WIDTH + 1;
  localparam int OP_W   = DATA_WIDTH + 2;
  localparam int LO_W   = (OP_W + 1) / 2;
  localparam int HI_W   = OP_W - LO_W;
  localparam int LOP_W  = LO_W + GAIN_W;
  localparam int HIP_W  = HI_W + GAIN_W;
  localparam int PW     = OP_W + GAIN_W;
  localparam int EXT_W  = (PW > TERM_W) ? PW : TERM_W;
  localparam int ISUM_W = TERM_W + 1;
  localparam int OSUM_W = TERM_W + 2;

  function automatic logic [TERM_W-1:0] scale(input logic [LOP_W-1:0] lo,
                                              input logic [HIP_W-1:0] hi);
    logic [EXT_W-1:0] full;
    logic [EXT_W-1:0] shifted;
    full    = (EXT_W'(hi) << LO_W) + EXT_W'(lo);
    shifted = full >> FRAC_BITS;
    if (shifted > EXT_W'(TERM_MAX)) begin
      return TERM_MAX;
    end
    return shifted[TERM_W-1:0];
  endfunction

  logic             job_err_neg;
  logic [MAG_W-1:0] job_err_mag;
  logic             job_large;
  logic             job_diff_neg;
  logic [OP_W-1:0]  job_diff_mag;
  logic [OP_W-1:0]  err_op;
  logic [GAIN_W-1:0] kp;
  logic             adv;

  // stage 1: partial products
  logic             s1_valid;
  logic             s1_err_neg;
  logic             s1_diff_neg;
  logic [LOP_W-1:0] s1_p_lo, s1_i_lo, s1_d_lo;
  logic [HIP_W-1:0] s1_p_hi, s1_i_hi, s1_d_hi;

  // stage 2: scaled magnitudes
  logic              s2_valid;
  logic              s2_err_neg;
  logic              s2_diff_neg;
  logic [TERM_W-1:0] s2_p_mag, s2_i_mag, s2_d_mag;

  // stage 3: integral and p plus d
  logic                      s3_valid;
  logic signed [ISUM_W-1:0]  s3_pd;
  logic signed [INTEG_W-1:0] s3_integ;
  logic                      s3_isat;
  logic signed [INTEG_W-1:0] integral_sum;

  logic signed [ISUM_W-1:0]  i_base, i_step, i_raw, i_lim, p_s, d_s;
  logic signed [INTEG_W-1:0] integ_next;
  logic                      isat_next;
  logic signed [ISUM_W-1:0]  pd_next;

  // stage 4: output register
  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_drive;
  logic                         out_osat;
  logic                         out_isat;
  logic signed [OSUM_W-1:0]     sum, o_lim, sum_sel;
  logic                         osat_next;

  assign {job_err_neg, job_err_mag, job_large, job_diff_neg, job_diff_mag} = job;
  assign err_op = OP_W'(job_err_mag);
  assign kp  = job_large ? cfg.prop_gain_large : cfg.prop_gain;
  assign adv = !out_valid || result.ready;
  assign pop = adv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err_neg  <= job_err_neg;
      s1_diff_neg <= job_diff_neg;
      s1_p_lo <= LOP_W'(err_op[LO_W-1:0]) * LOP_W'(kp);
      s1_p_hi <= HIP_W'(err_op[OP_W-1:LO_W]) * HIP_W'(kp);
      s1_i_lo <= LOP_W'(err_op[LO_W-1:0]) * LOP_W'(cfg.integral_gain);
      s1_i_hi <= HIP_W'(err_op[OP_W-1:LO_W]) * HIP_W'(cfg.integral_gain);
      s1_d_lo <= LOP_W'(job_diff_mag[LO_W-1:0]) * LOP_W'(cfg.deriv_gain);
      s1_d_hi <= HIP_W'(job_diff_mag[OP_W-1:LO_W]) * HIP_W'(cfg.deriv_gain);

      s2_err_neg  <= s1_err_neg;
      s2_diff_neg <= s1_diff_neg;
      s2_p_mag    <= scale(s1_p_lo, s1_p_hi);
      s2_i_mag    <= scale(s1_i_lo, s1_i_hi);
      s2_d_mag    <= scale(s1_d_lo, s1_d_hi);

      s3_pd    <= pd_next;
      s3_integ <= integ_next;
      s3_isat  <= isat_next;

      out_drive <= sum_sel[DATA_WIDTH-1:0];
      out_osat  <= osat_next;
      out_isat  <= s3_isat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      out_valid    <= 1'b0;
      integral_sum <= '0;
    end else if (adv) begin
      s1_valid  <= !qstat.empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      if (s2_valid) begin
        integral_sum <= integ_next;
      end
    end
  end

  // integral accumulate and clamp, signed p plus d
  always_comb begin
    i_base = ISUM_W'(integral_sum);
    i_step = $signed(ISUM_W'(s2_i_mag));
    i_raw  = s2_err_neg ? (i_base - i_step) : (i_base + i_step);
    i_lim  = $signed(ISUM_W'(cfg.integral_limit));
    if (i_raw > i_lim) begin
      integ_next = i_lim[INTEG_W-1:0];
      isat_next  = 1'b1;
    end else if (i_raw < -i_lim) begin
      integ_next = INTEG_W'(-i_lim);
      isat_next  = 1'b1;
    end else begin
      integ_next = i_raw[INTEG_W-1:0];
      isat_next  = 1'b0;
    end
    p_s     = s2_err_neg ? -$signed(ISUM_W'(s2_p_mag)) : $signed(ISUM_W'(s2_p_mag));
    d_s     = s2_diff_neg ? -$signed(ISUM_W'(s2_d_mag)) : $signed(ISUM_W'(s2_d_mag));
    pd_next = p_s + d_s;
  end

  // output sum and clamp, upper limit itself counts as saturated
  always_comb begin
    sum   = OSUM_W'(s3_pd) + OSUM_W'(s3_integ);
    o_lim = $signed(OSUM_W'(drive_limit));
    if (sum >= o_lim) begin
      sum_sel   = o_lim;
      osat_next = 1'b1;
    end else if (sum < -o_lim) begin
      sum_sel   = -o_lim;
      osat_next = 1'b1;
    end else begin
      sum_sel   = sum;
      osat_next = 1'b0;
    end
  end

  assign result.valid              = out_valid;
  assign result.drive              = out_drive;
  assign result.output_saturated   = out_osat;
  assign result.integral_saturated = out_isat;

endmodule

### sv/pid_regulator_sectional_gain.sv
// ----------------------------------------------------------------------------
// pid_regulator_sectional_gain
// positional pid regulator with sectional p gain, integral and output clamps
// ----------------------------------------------------------------------------
// path: a sample beat is held in a queue slot, then registered in stages 1, 2
//   and 3 and the output register; a stalled result side holds it
// throughput: one sample beat per cycle while the queue is not full; the integral
//   add and clamp in the back end is the only recurrence
// reset (rst, synchronous): registers to defaults, integral and previous
//   error to zero, queue and pipeline empty
module pid_regulator_sectional_gain import pidsg_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  pidsg_in_if.sink     sample,
  pidsg_out_if.source  result,
  pidsg_cfg_if.sink    cfg
);

  localparam int MAG_W = DATA_WIDTH + 1;
  // error sign and magnitude, section bit, difference sign and magnitude
  localparam int JOB_W = 2 * MAG_W + 4;
  // largest drive magnitude that fits the output field
  localparam logic [63:0] DRIVE_MAX = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

  cfg_t               regs;
  logic [LIMIT_W-1:0] drive_limit;
  queue_status_t      qstat;
  logic               push;
  logic               pop;
  logic [JOB_W-1:0]   job_in;
  logic [JOB_W-1:0]   job_out;
  logic signed [DATA_WIDTH:0] lim_s;
  logic signed [DATA_WIDTH:0] drive_s;

  // register writes are always taken, unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain       <= RST_PROP_GAIN;
      regs.prop_gain_large <= RST_PROP_GAIN_LARGE;
      regs.section_enable  <= RST_SECTION_ENABLE;
      regs.error_threshold <= RST_ERROR_THRESHOLD;
      regs.integral_gain   <= RST_INTEGRAL_GAIN;
      regs.deriv_gain      <= RST_DERIV_GAIN;
      regs.integral_limit  <= RST_INTEGRAL_LIMIT;
      regs.output_limit    <= RST_OUTPUT_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PROP_GAIN:       regs.prop_gain       <= cfg.data;
        REG_PROP_GAIN_LARGE: regs.prop_gain_large <= cfg.data;
        REG_SECTION_ENABLE:  regs.section_enable  <= cfg.data[0];
        REG_ERROR_THRESHOLD: regs.error_threshold <= cfg.data;
        REG_INTEGRAL_GAIN:   regs.integral_gain   <= cfg.data;
        REG_DERIV_GAIN:      regs.deriv_gain      <= cfg.data;
        REG_INTEGRAL_LIMIT:  regs.integral_limit  <= cfg.data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:    regs.output_limit    <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // output limit narrowed to what the drive field can hold
  assign drive_limit = (64'(regs.output_limit) > DRIVE_MAX)
                     ? DRIVE_MAX[LIMIT_W-1:0] : regs.output_limit;

  // front: error, section decision, clipped difference
  pidsg_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cfg    (regs),
    .qstat  (qstat),
    .push   (push),
    .job    (job_in)
  );

  // decoupling queue, lets the result side stall without blocking samples until it is full
  pidsg_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job_in),
    .pop       (pop),
    .head      (job_out),
    .status    (qstat)
  );

  // back: products, integral, output clamp
  pidsg_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (job_out),
    .qstat       (qstat),
    .pop         (pop),
    .cfg         (regs),
    .drive_limit (drive_limit),
    .result      (result)
  );

  assign lim_s   = $signed((DATA_WIDTH + 1)'(drive_limit));
  assign drive_s = (DATA_WIDTH + 1)'(result.drive);

  // queue count can never claim both full and empty
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  // a saturated drive sits exactly on one of the limits
  a_sat_on_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.output_saturated) |->
      ((drive_s == lim_s) || (drive_s == -lim_s)))
    else $error("saturated drive is off the limit");

  // an unsaturated drive lies in the open-top window
  a_unsat_window: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.output_saturated) |->
      ((drive_s < lim_s) && (drive_s >= -lim_s)))
    else $error("unsaturated drive outside the limit window");

endmodule
